[hw/rtl/bpa_pkg.sv]
// shared constants, types and codes of the bitmap page allocator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package bpa_pkg;

	// geometry of the physical store
	localparam int PAGE_COUNT = 65536;
	localparam int PAGE_SHIFT = 12;

	// field widths
	localparam int ADDR_W  = 28;
	localparam int LEN_W   = 29;
	localparam int LIMIT_W = 17;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

	// used map is kept as words of pages
	localparam int WORD_BITS = 64;
	localparam int OFF_W     = $clog2(WORD_BITS);
	localparam int WORDS     = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;

	// page numbers up to and including PAGE_COUNT
	localparam int PN_W = $clog2(PAGE_COUNT + 1);

	// width for range end arithmetic: holds page + page count and PAGE_COUNT + 1
	localparam int EW_A = 31 - PAGE_SHIFT;
	localparam int EW_B = (PN_W + 1 > LIMIT_W + 1) ? PN_W + 1 : LIMIT_W + 1;
	localparam int EW   = (EW_A > EW_B) ? EW_A : EW_B;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WA_W-1:0]      waddr_t;
	typedef logic [PN_W-1:0]      pnum_t;

	typedef enum logic [1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_FREE    = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_RESERVE = 2'd3
	} action_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// operations of the shared word unit
	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_SET   = 2'd1,
		OP_CLR   = 2'd2
	} unit_op_t;

	typedef struct packed {
		logic             found;
		logic [OFF_W-1:0] idx;
		word_t            wdata;
	} unit_res_t;

endpackage

[hw/rtl/bitmap_page_allocator.sv]
// top level of the bitmap page allocator: sequencer, output register, assertions
// uses bpa_pkg, bpa_map_store and bpa_word_unit
`timescale 1ns / 1ps

// usage
// - input channel (in_valid/in_ready) carries action, byte_address, range_length;
//   output channel (out_valid/out_ready) returns page_address and status, one
//   result transaction for every input transaction, in order
// - cfg_we/cfg_wdata writes page_limit; user writes only while idle (unchecked)
// - the used map lives in a 64-page-per-word memory; one word unit does the
//   masking, first-free search and update of every word, one word at a time
// - sequencing: every word visited takes a registered memory read, then an
//   evaluate and write back step; allocate visits words from page 0 up to the
//   first free page or the clamped limit (at most 1024), free visits one, a
//   range visits the words it spans; items with no words go straight to the
//   done state
// - in_ready is high only while the sequencer is idle; a finished result waits
//   in the output register and the next transaction is accepted meanwhile
// - receiver stall: a second result waits in the sequencer until the output
//   register empties
// - reset: page_limit returns to 65536, then a clearing pass over every word
//   marks every page used; in_ready stays low during it, config writes work
`default_nettype none

module bitmap_page_allocator
	import bpa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         action,
	input  wire logic [ADDR_W-1:0]  byte_address,
	input  wire logic [LEN_W-1:0]   range_length,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [ADDR_W-1:0]       page_address,
	output logic [1:0]              status,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata
);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_RD    = 5'b00100,
		S_EVAL  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	localparam logic [LEN_W:0] PMASK = (LEN_W + 1)'((64'd1 << PAGE_SHIFT) - 64'd1);
	localparam logic [EW-1:0]  PC_E  = EW'(PAGE_COUNT);

	state_t             state_q;
	waddr_t             word_q;
	pnum_t              lo_q;
	pnum_t              hi_q;
	unit_op_t           op_q;
	logic [1:0]         stat_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               out_valid_q;
	logic [ADDR_W-1:0]  page_address_q;
	logic [1:0]         status_q;
	logic [LIMIT_W-1:0] page_limit_q;

	// accept-time decode
	logic [EW-1:0]  page_e;
	logic [LEN_W:0] len_round;
	logic [EW-1:0]  count_e;
	logic [EW-1:0]  end_e;
	logic [EW-1:0]  stop_e;
	logic [EW-1:0]  lim_e;
	logic [EW-1:0]  nxt_lo;
	logic [EW-1:0]  nxt_hi;
	logic           nxt_work;
	logic [1:0]     nxt_stat;
	unit_op_t       nxt_op;

	// word loop
	pnum_t                 base;
	logic [PN_W:0]         next_base;
	logic                  more;
	pnum_t                 hit_page;
	logic [ADDR_W+PN_W-1:0] hit_wide;
	unit_res_t             res;
	word_t                 rdata;
	logic                  ram_we;
	word_t                 ram_wdata;
	logic                  ram_re;
	logic                  out_free;

	always_comb begin
		page_e    = EW'(byte_address >> PAGE_SHIFT);
		len_round = {1'b0, range_length} + PMASK;
		count_e   = EW'(len_round >> PAGE_SHIFT);
		end_e     = page_e + count_e;
		stop_e    = (end_e > PC_E) ? PC_E : end_e;
		lim_e     = (EW'(page_limit_q) > PC_E) ? PC_E : EW'(page_limit_q);

		case (action_t'(action))
			ACT_ALLOC: begin
				nxt_op   = OP_ALLOC;
				nxt_lo   = '0;
				nxt_hi   = lim_e;
				nxt_work = (lim_e != '0);
				nxt_stat = ST_NONE;
			end
			ACT_FREE: begin
				nxt_op   = OP_CLR;
				nxt_lo   = page_e;
				nxt_hi   = page_e + EW'(1);
				nxt_work = (page_e < PC_E);
				nxt_stat = (page_e < PC_E) ? ST_OK : ST_RANGE;
			end
			ACT_RELEASE, ACT_RESERVE: begin
				nxt_op   = (action_t'(action) == ACT_RESERVE) ? OP_SET : OP_CLR;
				nxt_lo   = page_e;
				nxt_hi   = stop_e;
				nxt_work = (page_e < stop_e);
				nxt_stat = (end_e > PC_E) ? ST_RANGE : ST_OK;
			end
			default: begin
				nxt_op   = OP_CLR;
				nxt_lo   = '0;
				nxt_hi   = '0;
				nxt_work = 1'b0;
				nxt_stat = ST_OK;
			end
		endcase
	end

	// page number of bit 0 of the current word
	assign base      = PN_W'({word_q, OFF_W'(0)});
	assign next_base = {1'b0, base} + (PN_W + 1)'(WORD_BITS);
	assign more      = next_base < {1'b0, hi_q};
	assign hit_page  = base + PN_W'(res.idx);
	assign hit_wide  = (ADDR_W + PN_W)'(hit_page) << PAGE_SHIFT;

	bpa_word_unit u_unit (
		.op   (op_q),
		.word (rdata),
		.base (base),
		.lo   (lo_q),
		.hi   (hi_q),
		.res  (res)
	);

	assign ram_re    = (state_q == S_RD);
	assign ram_we    = (state_q == S_CLEAR) ||
	                   ((state_q == S_EVAL) && ((op_q != OP_ALLOC) || res.found));
	assign ram_wdata = (state_q == S_CLEAR) ? '1 : res.wdata;

	bpa_map_store u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (word_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (word_q),
		.rdata (rdata)
	);

	assign out_free = !out_valid_q || out_ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			word_q  <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (word_q == WA_W'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						word_q <= word_q + WA_W'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						word_q  <= nxt_lo[OFF_W +: WA_W];
						state_q <= nxt_work ? S_RD : S_DONE;
					end
				end
				S_RD: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if ((op_q == OP_ALLOC) && res.found) begin
						state_q <= S_DONE;
					end else if (more) begin
						word_q  <= word_q + WA_W'(1);
						state_q <= S_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// per-item working registers, no reset needed
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			lo_q   <= nxt_lo[PN_W-1:0];
			hi_q   <= nxt_hi[PN_W-1:0];
			op_q   <= nxt_op;
			stat_q <= nxt_stat;
			addr_q <= '0;
		end else if ((state_q == S_EVAL) && (op_q == OP_ALLOC) && res.found) begin
			stat_q <= ST_OK;
			addr_q <= hit_wide[ADDR_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			page_address_q <= addr_q;
			status_q       <= stat_q;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			page_limit_q <= cfg_wdata;
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign page_address = page_address_q;
	assign status       = status_q;

	// one transaction at a time through the sequencer
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction accepted while busy");

	// a failed allocate reports no address
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NONE) |-> (page_address == '0))
		else $error("no free page but address nonzero");

	// map writes only from the clearing pass or the evaluate step
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == S_CLEAR) || (state_q == S_EVAL)))
		else $error("map written outside clear or evaluate");

	// returned addresses are page aligned
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (page_address[PAGE_SHIFT-1:0] == '0))
		else $error("unaligned page address");

endmodule

`default_nettype wire

[hw/rtl/bpa_map_store.sv]
// used map storage: one word of page bits per entry
// one write port, one registered read port; uses bpa_pkg
`timescale 1ns / 1ps

module bpa_map_store
	import bpa_pkg::*;
(
	input  logic   clk,
	input  logic   we,
	input  waddr_t waddr,
	input  word_t  wdata,
	input  logic   re,
	input  waddr_t raddr,
	output word_t  rdata
);

	word_t mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/bpa_word_unit.sv]
// shared word unit: page window mask, first free page search, word update
// pure logic; uses bpa_pkg
`timescale 1ns / 1ps

module bpa_word_unit
	import bpa_pkg::*;
(
	input  unit_op_t  op,
	input  word_t     word,
	input  pnum_t     base,
	input  pnum_t     lo,
	input  pnum_t     hi,
	output unit_res_t res
);

	word_t mask;
	word_t cand;
	word_t first;

	always_comb begin
		// pages of this word inside [lo, hi)
		for (int i = 0; i < WORD_BITS; i++) begin
			mask[i] = (({1'b0, base} + (PN_W + 1)'(i)) >= {1'b0, lo}) &&
			          (({1'b0, base} + (PN_W + 1)'(i)) <  {1'b0, hi});
		end
		cand  = ~word & mask;
		first = cand & (~cand + WORD_BITS'(1));

		res.found = |cand;
		res.idx   = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			res.idx = res.idx | (first[i] ? OFF_W'(i) : OFF_W'(0));
		end

		case (op)
			OP_ALLOC: res.wdata = word | first;
			OP_SET:   res.wdata = word | mask;
			OP_CLR:   res.wdata = word & ~mask;
			default:  res.wdata = word;
		endcase
	end

endmodule
